@@ hdl/cfba_pkg.sv @@
// ----------------------------------------------------------------------------
// Chained free block allocator package
// Shared constants, action and status codes, controller states and the
// command and status types that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cfba_pkg;

   // Default sizing of the block.
   localparam int DEF_NUM_BLOCKS  = 256;
   localparam int DEF_CACHE_SLOTS = 16;

   // Field widths fixed by the interface.
   localparam int ACTION_W = 2;
   localparam int BLOCK_W  = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 9;

   // Width of the group base counter used by the format sequence.
   localparam int BLK_W = 10;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FORMAT = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADSIZE = 2'd2;

   // Free count saturates here.
   localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

   // Controller states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_POP,
      S_LINK,
      S_RELOAD,
      S_SPILL,
      S_CHECK,
      S_FILL,
      S_FINISH
   } ctrl_state_type;

   // Commands from the controller to the datapath, one per cycle.
   typedef enum logic [4:0] {
      CMD_IDLE,
      CMD_LATCH,
      CMD_MARK_EMPTY,
      CMD_MARK_BAD,
      CMD_READ_SLOT,
      CMD_READ_LINK,
      CMD_POP,
      CMD_TAKE_HEAD,
      CMD_RELOAD_STEP,
      CMD_SPILL_STEP,
      CMD_PUSH,
      CMD_CHECK_STEP,
      CMD_FILL_START,
      CMD_FILL_STEP,
      CMD_RESPOND
   } dp_cmd_type;

   // Status flags from the datapath to the controller.
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                count_zero;
      logic                slot_zero;
      logic                slot_full;
      logic                sweep_end;
      logic                check_done;
      logic                size_ok;
      logic                fill_last;
   } dp_status_type;

endpackage

`default_nettype wire

@@ hdl/cfba_controller.sv @@
// ----------------------------------------------------------------------------
// Chained free block allocator controller
// State machine that sequences each action through the datapath and owns
// the request and response handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module cfba_controller (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output cfba_pkg::dp_cmd_type   cmd,
   input  cfba_pkg::dp_status_type status
);
   import cfba_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           out_free;

   // The response register may be loaded when empty or being emptied.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // State and response valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state, commands and handshake outputs.
   always_comb begin
      state_in     = state_ff;
      cmd          = CMD_IDLE;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = CMD_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.action)
               ACT_ALLOC: begin
                  if (status.count_zero) begin
                     cmd      = CMD_MARK_EMPTY;
                     state_in = S_FINISH;
                  end else if (status.slot_zero) begin
                     cmd      = CMD_READ_LINK;
                     state_in = S_LINK;
                  end else begin
                     cmd      = CMD_READ_SLOT;
                     state_in = S_POP;
                  end
               end
               ACT_FREE: begin
                  if (status.slot_full) begin
                     state_in = S_SPILL;
                  end else begin
                     cmd      = CMD_PUSH;
                     state_in = S_FINISH;
                  end
               end
               ACT_FORMAT: begin
                  state_in = S_CHECK;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_POP: begin
            cmd      = CMD_POP;
            state_in = S_FINISH;
         end
         S_LINK: begin
            cmd      = CMD_TAKE_HEAD;
            state_in = S_RELOAD;
         end
         S_RELOAD: begin
            cmd = CMD_RELOAD_STEP;
            if (status.sweep_end) begin
               state_in = S_FINISH;
            end
         end
         S_SPILL: begin
            cmd = CMD_SPILL_STEP;
            if (status.sweep_end) begin
               state_in = S_FINISH;
            end
         end
         S_CHECK: begin
            if (status.check_done) begin
               if (status.size_ok) begin
                  cmd      = CMD_FILL_START;
                  state_in = S_FILL;
               end else begin
                  cmd      = CMD_MARK_BAD;
                  state_in = S_FINISH;
               end
            end else begin
               cmd = CMD_CHECK_STEP;
            end
         end
         S_FILL: begin
            cmd = CMD_FILL_STEP;
            if (status.fill_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd          = CMD_RESPOND;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hdl/cfba_datapath.sv @@
// ----------------------------------------------------------------------------
// Chained free block allocator datapath
// Free number cache, list store, head, slot pointer, free count and the
// configuration register, driven by controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module cfba_datapath #(
   parameter int NUM_BLOCKS  = cfba_pkg::DEF_NUM_BLOCKS,
   parameter int CACHE_SLOTS = cfba_pkg::DEF_CACHE_SLOTS
) (
   input  wire                             clock,
   input  wire                             reset,
   input  cfba_pkg::dp_cmd_type            cmd,
   output cfba_pkg::dp_status_type         status,
   input  wire [cfba_pkg::ACTION_W-1:0]    req_action,
   input  wire [cfba_pkg::BLOCK_W-1:0]     req_block_id,
   input  wire                             csr_wr_en,
   input  wire [cfba_pkg::COUNT_W-1:0]     csr_wr_data,
   output logic [cfba_pkg::BLOCK_W-1:0]    rsp_granted_block,
   output logic [cfba_pkg::STATUS_W-1:0]   rsp_status,
   output logic [cfba_pkg::COUNT_W-1:0]    rsp_free_count
);
   import cfba_pkg::*;

   // Only block numbers below 256 can ever be named, so the store stops there.
   localparam int STORE_BLOCKS = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;
   localparam int STORE_DEPTH  = STORE_BLOCKS * CACHE_SLOTS;
   localparam int STORE_AW     = $clog2(STORE_DEPTH);
   localparam int SLOT_W       = $clog2(CACHE_SLOTS);
   localparam int CNT_W        = $clog2(CACHE_SLOTS + 1);
   localparam int MUL_W        = 9 + CNT_W;

   localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(CACHE_SLOTS - 1);
   localparam logic [CNT_W-1:0]   CNT_END    = CNT_W'(CACHE_SLOTS);
   localparam logic [CNT_W-1:0]   CNT_LAST   = CNT_W'(CACHE_SLOTS - 1);
   localparam logic [BLK_W-1:0]   BLK_STEP   = BLK_W'(CACHE_SLOTS);
   localparam logic [COUNT_W-1:0] SIZE_MIN   = COUNT_W'(CACHE_SLOTS);
   localparam logic [COUNT_W-1:0] SIZE_MAX   = COUNT_W'(STORE_BLOCKS);
   localparam logic [COUNT_W-1:0] HEAD_LIMIT = COUNT_W'(STORE_BLOCKS);
   localparam logic [MUL_W-1:0]   MUL_SLOTS  = MUL_W'(CACHE_SLOTS);

   // Architectural state.
   logic [COUNT_W-1:0]  total_blocks_ff, total_blocks_in;
   logic [BLOCK_W-1:0]  head_ff, head_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   // Per action working registers.
   logic [ACTION_W-1:0] act_ff, act_in;
   logic [BLOCK_W-1:0]  id_ff, id_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [BLK_W-1:0]    blk_ff, blk_in;
   logic [BLOCK_W-1:0]  res_grant_ff, res_grant_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;

   // Response payload.
   logic [BLOCK_W-1:0]  rsp_grant_ff, rsp_grant_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // Memories and their ports.
   logic [BLOCK_W-1:0]  cache_mem [CACHE_SLOTS];
   logic [BLOCK_W-1:0]  list_mem [STORE_DEPTH];
   logic                cache_rd_en, cache_wr_en;
   logic [SLOT_W-1:0]   cache_rd_addr, cache_wr_addr;
   logic [BLOCK_W-1:0]  cache_wr_data, cache_rd_ff;
   logic                list_rd_en, list_wr_en;
   logic [STORE_AW-1:0] list_rd_addr, list_wr_addr;
   logic [BLOCK_W-1:0]  list_wr_data, list_rd_ff;

   // Address and helper terms.
   logic [8:0]          mul_blk;
   logic [MUL_W-1:0]    list_base;
   logic [MUL_W-1:0]    addr_cnt;
   logic [MUL_W-1:0]    addr_prev;
   logic [CNT_W-1:0]    cnt_prev;
   logic [BLK_W-1:0]    fill_sum;
   logic [BLOCK_W-1:0]  fill_value;
   logic [COUNT_W-1:0]  count_inc;
   logic                head_ok;
   logic                cnt_live;

   // The list base of the head, or of the group being formatted.
   assign mul_blk   = (cmd == CMD_FILL_STEP) ? blk_ff[8:0] : {1'b0, head_ff};
   assign list_base = MUL_W'(mul_blk) * MUL_SLOTS;
   assign cnt_prev  = cnt_ff - CNT_W'(1);
   assign addr_cnt  = list_base + MUL_W'(cnt_ff);
   assign addr_prev = list_base + MUL_W'(cnt_prev);
   assign head_ok   = {1'b0, head_ff} < HEAD_LIMIT;
   assign cnt_live  = cnt_ff < CNT_END;

   // Format contents: slot 0 links to the next group, others count up.
   assign fill_sum   = blk_ff + ((cnt_ff == '0) ? BLK_STEP : BLK_W'(cnt_ff));
   assign fill_value = fill_sum[BLOCK_W-1:0];

   // Free count with saturation.
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);

   // Status flags for the controller.
   always_comb begin
      status.action     = act_ff;
      status.count_zero = count_ff == '0;
      status.slot_zero  = slot_ff == '0;
      status.slot_full  = slot_ff == SLOT_LAST;
      status.sweep_end  = cnt_ff == CNT_END;
      status.check_done = blk_ff >= BLK_W'(total_blocks_ff);
      status.size_ok    = (blk_ff == BLK_W'(total_blocks_ff))
                          && (total_blocks_ff >= SIZE_MIN)
                          && (total_blocks_ff <= SIZE_MAX);
      status.fill_last  = (cnt_ff == CNT_LAST)
                          && (blk_ff + BLK_STEP == BLK_W'(total_blocks_ff));
   end

   // Command decode: next values and memory port control.
   always_comb begin
      total_blocks_in = csr_wr_en ? csr_wr_data : total_blocks_ff;
      head_in         = head_ff;
      slot_in         = slot_ff;
      count_in        = count_ff;
      act_in          = act_ff;
      id_in           = id_ff;
      cnt_in          = cnt_ff;
      blk_in          = blk_ff;
      res_grant_in    = res_grant_ff;
      res_status_in   = res_status_ff;
      rsp_grant_in    = rsp_grant_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_count_in    = rsp_count_ff;
      cache_rd_en     = 1'b0;
      cache_rd_addr   = '0;
      cache_wr_en     = 1'b0;
      cache_wr_addr   = '0;
      cache_wr_data   = '0;
      list_rd_en      = 1'b0;
      list_rd_addr    = '0;
      list_wr_en      = 1'b0;
      list_wr_addr    = '0;
      list_wr_data    = '0;
      case (cmd)
         CMD_LATCH: begin
            act_in        = req_action;
            id_in         = req_block_id;
            cnt_in        = '0;
            blk_in        = '0;
            res_grant_in  = '0;
            res_status_in = ST_OK;
         end
         CMD_MARK_EMPTY: begin
            res_status_in = ST_EMPTY;
         end
         CMD_MARK_BAD: begin
            res_status_in = ST_BADSIZE;
         end
         CMD_READ_SLOT: begin
            cache_rd_en   = 1'b1;
            cache_rd_addr = slot_ff;
         end
         CMD_READ_LINK: begin
            cache_rd_en   = 1'b1;
            cache_rd_addr = '0;
         end
         CMD_POP: begin
            res_grant_in = cache_rd_ff;
            slot_in      = slot_ff - SLOT_W'(1);
            count_in     = count_ff - COUNT_W'(1);
         end
         CMD_TAKE_HEAD: begin
            res_grant_in = head_ff;
            head_in      = cache_rd_ff;
            slot_in      = SLOT_LAST;
            count_in     = count_ff - COUNT_W'(1);
         end
         CMD_RELOAD_STEP: begin
            // Read one list word per cycle and write it to the cache next cycle.
            if (cnt_live) begin
               list_rd_en   = head_ok;
               list_rd_addr = addr_cnt[STORE_AW-1:0];
               cnt_in       = cnt_ff + CNT_W'(1);
            end
            if (cnt_ff != '0) begin
               cache_wr_en   = 1'b1;
               cache_wr_addr = cnt_prev[SLOT_W-1:0];
               cache_wr_data = head_ok ? list_rd_ff : '0;
            end
         end
         CMD_SPILL_STEP: begin
            // Copy the cache into the head's list, then link in the freed block.
            if (cnt_live) begin
               cache_rd_en   = 1'b1;
               cache_rd_addr = cnt_ff[SLOT_W-1:0];
               cnt_in        = cnt_ff + CNT_W'(1);
            end
            if (cnt_ff != '0 && head_ok) begin
               list_wr_en   = 1'b1;
               list_wr_addr = addr_prev[STORE_AW-1:0];
               list_wr_data = cache_rd_ff;
            end
            if (!cnt_live) begin
               cache_wr_en   = 1'b1;
               cache_wr_addr = '0;
               cache_wr_data = head_ff;
               head_in       = id_ff;
               slot_in       = '0;
               count_in      = count_inc;
            end
         end
         CMD_PUSH: begin
            slot_in       = slot_ff + SLOT_W'(1);
            cache_wr_en   = 1'b1;
            cache_wr_addr = slot_ff + SLOT_W'(1);
            cache_wr_data = id_ff;
            count_in      = count_inc;
         end
         CMD_CHECK_STEP: begin
            blk_in = blk_ff + BLK_STEP;
         end
         CMD_FILL_START: begin
            blk_in = '0;
            cnt_in = '0;
         end
         CMD_FILL_STEP: begin
            // One list word per cycle; group zero also goes into the cache.
            list_wr_en   = 1'b1;
            list_wr_addr = addr_cnt[STORE_AW-1:0];
            list_wr_data = fill_value;
            if (blk_ff == '0) begin
               cache_wr_en   = 1'b1;
               cache_wr_addr = cnt_ff[SLOT_W-1:0];
               cache_wr_data = fill_value;
            end
            if (cnt_ff == CNT_LAST) begin
               cnt_in = '0;
               blk_in = blk_ff + BLK_STEP;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (status.fill_last) begin
               head_in  = '0;
               slot_in  = SLOT_LAST;
               count_in = total_blocks_ff;
            end
         end
         CMD_RESPOND: begin
            rsp_grant_in  = res_grant_ff;
            rsp_status_in = res_status_ff;
            rsp_count_in  = count_ff;
         end
         default: begin
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_blocks_ff <= 9'd256;
         head_ff         <= '0;
         slot_ff         <= '0;
         count_ff        <= '0;
         act_ff          <= ACT_ALLOC;
         cnt_ff          <= '0;
         blk_ff          <= '0;
      end else begin
         total_blocks_ff <= total_blocks_in;
         head_ff         <= head_in;
         slot_ff         <= slot_in;
         count_ff        <= count_in;
         act_ff          <= act_in;
         cnt_ff          <= cnt_in;
         blk_ff          <= blk_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      res_grant_ff  <= res_grant_in;
      res_status_ff <= res_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Free number cache: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cache_wr_en) begin
         cache_mem[cache_wr_addr] <= cache_wr_data;
      end
      if (cache_rd_en) begin
         cache_rd_ff <= cache_mem[cache_rd_addr];
      end
   end

   // List store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (list_wr_en) begin
         list_mem[list_wr_addr] <= list_wr_data;
      end
      if (list_rd_en) begin
         list_rd_ff <= list_mem[list_rd_addr];
      end
   end

   assign rsp_granted_block = rsp_grant_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_free_count    = rsp_count_ff;

endmodule

`default_nettype wire

@@ hdl/chained_free_block_allocator.sv @@
// ----------------------------------------------------------------------------
// Chained free block allocator
// Hands out and takes back block numbers from a chained free list.
// Requests arrive on req_ (action and block number) with a valid/ready
// transfer; every request gives exactly one response on rsp_ (granted
// block, status and free count after the action). csr_wr_en writes the
// format size from csr_wr_data; the user must write it only while the
// block is idle, which the block does not enforce. Requests are handled
// one at a time. A free into the cache, a failed allocate and the unused
// action go from the decode state to the finish state; an allocate from
// the cache passes through a pop state first. An allocate that empties
// the cache reloads the next list from the list store, one word a cycle.
// A free into a full cache writes it back the same way. Format steps
// through the size check, then writes the list store one word a cycle,
// total_blocks words in all. The next request is taken in the cycle after
// the response is loaded, while that response may still wait; if the
// receiver stalls, the next response holds until the register empties.
// After reset nothing is free, the format size is 256 and no response is
// pending; the free list must be formatted before it is used.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_free_block_allocator #(
   parameter int NUM_BLOCKS  = cfba_pkg::DEF_NUM_BLOCKS,
   parameter int CACHE_SLOTS = cfba_pkg::DEF_CACHE_SLOTS
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire [cfba_pkg::ACTION_W-1:0]    req_action,
   input  wire [cfba_pkg::BLOCK_W-1:0]     req_block_id,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic [cfba_pkg::BLOCK_W-1:0]    rsp_granted_block,
   output logic [cfba_pkg::STATUS_W-1:0]   rsp_status,
   output logic [cfba_pkg::COUNT_W-1:0]    rsp_free_count,
   input  wire                             csr_wr_en,
   input  wire [cfba_pkg::COUNT_W-1:0]     csr_wr_data
);
   import cfba_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencing and handshakes.
   cfba_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Storage and arithmetic.
   cfba_datapath #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .CACHE_SLOTS (CACHE_SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_action        (req_action),
      .req_block_id      (req_block_id),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_granted_block (rsp_granted_block),
      .rsp_status        (rsp_status),
      .rsp_free_count    (rsp_free_count)
   );

endmodule

`default_nettype wire
